@@ hdl/gcq_pkg.sv @@
package gcq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_STEPS   = 16;
    localparam int MAX_RESULTS = 32;
    localparam int JOBQ_DEPTH  = 2;

    localparam int CMD_W = 3;
    localparam int PIN_W = 8;
    localparam int VAL_W = 16;
    localparam int FLG_W = 8;
    localparam int DLY_W = 32;
    localparam int SRC_W = 2;

    localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SIW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int SAW  = SIW + 1;
    localparam int SCW  = $clog2(MAX_STEPS + 1);
    localparam int RCW  = $clog2(MAX_RESULTS + 1);
    localparam int JAW  = (QAW > SAW) ? QAW : SAW;
    localparam int JQAW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int JQCW = $clog2(JOBQ_DEPTH + 1);

    localparam int QW  = PIN_W + VAL_W + FLG_W;
    localparam int PVW = PIN_W + VAL_W;
    localparam int STEP_DEPTH = 2 ** SAW;

    localparam logic [SRC_W-1:0] SRC_DIRECT = 2'd0;
    localparam logic [SRC_W-1:0] SRC_FLUSH  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_STEP   = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_FLUSH = 3'd4,
        CMD_CLEAR = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        JOB_DIRECT = 2'd0,
        JOB_FLUSH  = 2'd1,
        JOB_STEP   = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic [PIN_W-1:0]       pin;
        logic [VAL_W-1:0]       value;
        logic [FLG_W-1:0]       flags;
        logic [JAW-1:0]         addr;
        logic [RCW-1:0]         cnt;
        logic                   ovf;
    } t_job;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic [VAL_W-1:0] value;
        logic [FLG_W-1:0] flags;
    } t_qent;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic [VAL_W-1:0] value;
    } t_sent;

    typedef struct packed {
        logic           we;
        logic [QAW-1:0] addr;
        t_qent          data;
    } t_qwr;

    typedef struct packed {
        logic             we;
        logic [SAW-1:0]   addr;
        t_sent            data;
        logic [DLY_W-1:0] delay;
    } t_swr;

    function automatic logic [QAW-1:0] q_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

endpackage

@@ hdl/gcq_ram.sv @@
module gcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/gcq_front.sv @@
module gcq_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [gcq_pkg::CMD_W-1:0] i_command,
    input  logic [gcq_pkg::PIN_W-1:0] i_pin,
    input  logic [gcq_pkg::VAL_W-1:0] i_value,
    input  logic [gcq_pkg::FLG_W-1:0] i_flags,
    input  logic [gcq_pkg::DLY_W-1:0] i_delay_ms,
    input  logic                      i_step_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_exec_mode,
    input  logic                      i_jobq_full,
    output logic                      o_push,
    output gcq_pkg::t_job             o_job,
    input  logic                      i_mem_done,
    output gcq_pkg::t_qwr             o_qwr,
    output gcq_pkg::t_swr             o_swr,
    output logic                      o_dly_re,
    output logic [gcq_pkg::SAW-1:0]   o_dly_raddr,
    input  logic [gcq_pkg::DLY_W-1:0] i_dly_rdata
);

    import gcq_pkg::*;

    localparam int SUMW = ((QAW > RCW) ? QAW : RCW) + 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RD   = 3'b010,
        F_LD   = 3'b100
    } t_fstate;

    t_fstate          r_state, n_state;
    logic             r_exec_mode, n_exec_mode;
    logic [QAW-1:0]   r_q_head, n_q_head;
    logic [QAW-1:0]   r_q_tail, n_q_tail;
    logic [QCW-1:0]   r_q_count, n_q_count;
    logic [SCW-1:0]   r_stage_cnt, n_stage_cnt;
    logic             r_bank, n_bank;
    logic [SCW-1:0]   r_act_len, n_act_len;
    logic [SCW-1:0]   r_step_idx, n_step_idx;
    logic [DLY_W-1:0] r_elapsed, n_elapsed;
    logic             r_running, n_running;
    logic             r_ovf, n_ovf;
    logic             r_mem_wait, n_mem_wait;
    logic [SAW-1:0]   r_fetch_addr, n_fetch_addr;
    logic [DLY_W-1:0] r_cur_delay, n_cur_delay;

    logic             ready;
    logic             accept;
    logic [DLY_W-1:0] el_inc;
    logic [SCW-1:0]   idx_next;
    logic [SCW-1:0]   stage_next;
    logic             ovf_next;
    logic             sb;
    logic [RCW-1:0]   flush_m;
    logic [SUMW-1:0]  head_sum;

    assign ready       = (r_state == F_IDLE) && !r_mem_wait && !i_jobq_full;
    assign accept      = i_valid && ready;
    assign o_stall     = !ready;
    assign o_cfg_ready = 1'b1;
    assign o_dly_raddr = r_fetch_addr;

    always_comb begin
        n_state      = r_state;
        n_exec_mode  = r_exec_mode;
        n_q_head     = r_q_head;
        n_q_tail     = r_q_tail;
        n_q_count    = r_q_count;
        n_stage_cnt  = r_stage_cnt;
        n_bank       = r_bank;
        n_act_len    = r_act_len;
        n_step_idx   = r_step_idx;
        n_elapsed    = r_elapsed;
        n_running    = r_running;
        n_ovf        = r_ovf;
        n_mem_wait   = r_mem_wait;
        n_fetch_addr = r_fetch_addr;
        n_cur_delay  = r_cur_delay;
        o_push       = 1'b0;
        o_job        = '0;
        o_qwr        = '0;
        o_swr        = '0;
        o_dly_re     = 1'b0;
        el_inc       = (r_elapsed == {DLY_W{1'b1}}) ? r_elapsed : r_elapsed + DLY_W'(1);
        idx_next     = r_step_idx + SCW'(1);
        stage_next   = r_stage_cnt;
        ovf_next     = r_ovf;
        sb           = !r_bank;
        flush_m      = (int'(r_q_count) < MAX_RESULTS) ? RCW'(r_q_count)
                                                       : RCW'(MAX_RESULTS);
        head_sum     = SUMW'(r_q_head) + SUMW'(flush_m);

        if (i_mem_done) begin
            n_mem_wait = 1'b0;
        end

        case (r_state)
            F_RD: begin
                o_dly_re = 1'b1;
                n_state  = F_LD;
            end
            F_LD: begin
                n_cur_delay = i_dly_rdata;
                n_state     = F_IDLE;
            end
            default: begin
            end
        endcase

        if (accept) begin
            case (t_cmd'(i_command))
                CMD_TICK: begin
                    if (r_running) begin
                        n_elapsed = el_inc;
                        if (r_step_idx >= r_act_len) begin
                            n_running = 1'b0;
                        end else if (el_inc >= r_cur_delay) begin
                            n_step_idx = idx_next;
                            if (idx_next < r_act_len) begin
                                n_elapsed    = '0;
                                o_push       = 1'b1;
                                o_job.kind   = JOB_STEP;
                                o_job.addr   = JAW'({r_bank, idx_next[SIW-1:0]});
                                o_job.cnt    = RCW'(1);
                                o_job.ovf    = r_ovf;
                                n_mem_wait   = 1'b1;
                                n_fetch_addr = {r_bank, idx_next[SIW-1:0]};
                                n_state      = F_RD;
                            end else begin
                                n_running = 1'b0;
                            end
                        end
                    end
                end
                CMD_WRITE: begin
                    if (!r_exec_mode) begin
                        o_push      = 1'b1;
                        o_job.kind  = JOB_DIRECT;
                        o_job.pin   = i_pin;
                        o_job.value = i_value;
                        o_job.flags = i_flags;
                        o_job.cnt   = RCW'(1);
                        o_job.ovf   = r_ovf;
                    end else if (r_q_count < QCW'(QUEUE_DEPTH)) begin
                        o_qwr.we         = 1'b1;
                        o_qwr.addr       = r_q_tail;
                        o_qwr.data.pin   = i_pin;
                        o_qwr.data.value = i_value;
                        o_qwr.data.flags = i_flags;
                        n_q_tail         = q_inc(r_q_tail);
                        n_q_count        = r_q_count + QCW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                CMD_LOAD: begin
                    if (r_stage_cnt < SCW'(MAX_STEPS)) begin
                        o_swr.we         = 1'b1;
                        o_swr.addr       = {sb, r_stage_cnt[SIW-1:0]};
                        o_swr.data.pin   = i_pin;
                        o_swr.data.value = i_value;
                        o_swr.delay      = i_delay_ms;
                        stage_next       = r_stage_cnt + SCW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    n_ovf       = ovf_next;
                    n_stage_cnt = stage_next;
                    if (i_step_last && (stage_next != '0)) begin
                        n_bank       = sb;
                        n_act_len    = stage_next;
                        n_stage_cnt  = '0;
                        n_step_idx   = '0;
                        n_elapsed    = '0;
                        n_running    = 1'b1;
                        o_push       = 1'b1;
                        o_job.kind   = JOB_STEP;
                        o_job.addr   = JAW'({sb, {SIW{1'b0}}});
                        o_job.cnt    = RCW'(1);
                        o_job.ovf    = ovf_next;
                        n_mem_wait   = 1'b1;
                        n_fetch_addr = {sb, {SIW{1'b0}}};
                        n_state      = F_RD;
                    end
                end
                CMD_STOP: begin
                    n_running = 1'b0;
                end
                CMD_FLUSH: begin
                    if (flush_m != '0) begin
                        o_push     = 1'b1;
                        o_job.kind = JOB_FLUSH;
                        o_job.addr = JAW'(r_q_head);
                        o_job.cnt  = flush_m;
                        o_job.ovf  = r_ovf;
                        n_mem_wait = 1'b1;
                        n_q_head   = (head_sum >= SUMW'(QUEUE_DEPTH))
                                   ? QAW'(head_sum - SUMW'(QUEUE_DEPTH))
                                   : QAW'(head_sum);
                        n_q_count  = r_q_count - QCW'(flush_m);
                    end
                end
                CMD_CLEAR: begin
                    n_q_count = '0;
                    n_q_tail  = r_q_head;
                end
                default: begin
                end
            endcase
        end

        if (i_cfg_valid) begin
            n_exec_mode = i_cfg_exec_mode;
            if (!i_cfg_exec_mode) begin
                n_q_count = '0;
                n_q_tail  = r_q_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_exec_mode <= 1'b0;
            r_q_head    <= '0;
            r_q_tail    <= '0;
            r_q_count   <= '0;
            r_stage_cnt <= '0;
            r_bank      <= 1'b0;
            r_act_len   <= '0;
            r_step_idx  <= '0;
            r_elapsed   <= '0;
            r_running   <= 1'b0;
            r_ovf       <= 1'b0;
            r_mem_wait  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exec_mode <= n_exec_mode;
            r_q_head    <= n_q_head;
            r_q_tail    <= n_q_tail;
            r_q_count   <= n_q_count;
            r_stage_cnt <= n_stage_cnt;
            r_bank      <= n_bank;
            r_act_len   <= n_act_len;
            r_step_idx  <= n_step_idx;
            r_elapsed   <= n_elapsed;
            r_running   <= n_running;
            r_ovf       <= n_ovf;
            r_mem_wait  <= n_mem_wait;
        end
        r_fetch_addr <= n_fetch_addr;
        r_cur_delay  <= n_cur_delay;
    end

endmodule

@@ hdl/gcq_jobq.sv @@
module gcq_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gcq_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output gcq_pkg::t_job o_job,
    output logic          o_empty
);

    import gcq_pkg::*;

    t_job              r_mem [JOBQ_DEPTH];
    logic [JQAW-1:0]   r_wp, n_wp;
    logic [JQAW-1:0]   r_rp, n_rp;
    logic [JQCW-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == JQCW'(JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + JQAW'(1);
        end
        if (i_pop) begin
            n_rp = r_rp + JQAW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + JQCW'(1);
            2'b01:   n_cnt = r_cnt - JQCW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ hdl/gcq_back.sv @@
module gcq_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  gcq_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_mem_done,
    output logic                      o_q_re,
    output logic [gcq_pkg::QAW-1:0]   o_q_raddr,
    input  logic [gcq_pkg::QW-1:0]    i_q_rdata,
    output logic                      o_s_re,
    output logic [gcq_pkg::SAW-1:0]   o_s_raddr,
    input  logic [gcq_pkg::PVW-1:0]   i_s_rdata,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [gcq_pkg::PIN_W-1:0] o_write_pin,
    output logic [gcq_pkg::VAL_W-1:0] o_write_value,
    output logic [gcq_pkg::FLG_W-1:0] o_write_flags,
    output logic [gcq_pkg::SRC_W-1:0] o_write_source,
    output logic                      o_last_of_run,
    output logic                      o_overflow_seen
);

    import gcq_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_DIRECT = 4'b0010,
        B_READ   = 4'b0100,
        B_EMIT   = 4'b1000
    } t_bstate;

    t_bstate          r_state, n_state;
    t_job             r_job, n_job;
    logic [RCW-1:0]   r_left, n_left;
    logic [JAW-1:0]   r_addr, n_addr;
    logic             r_o_valid, n_o_valid;
    logic [PIN_W-1:0] r_o_pin, n_o_pin;
    logic [VAL_W-1:0] r_o_value, n_o_value;
    logic [FLG_W-1:0] r_o_flags, n_o_flags;
    logic [SRC_W-1:0] r_o_src, n_o_src;
    logic             r_o_last, n_o_last;
    logic             r_o_ovf, n_o_ovf;

    logic             out_free;
    logic             is_flush;
    logic             rd_en;
    logic [JAW-1:0]   rd_addr;
    logic [JAW-1:0]   addr_next;
    t_qent            q_ent;
    t_sent            s_ent;

    assign out_free  = !r_o_valid || !i_stall;
    assign is_flush  = (r_job.kind == JOB_FLUSH);
    assign addr_next = is_flush ? JAW'(q_inc(r_addr[QAW-1:0])) : r_addr;
    assign q_ent     = t_qent'(i_q_rdata);
    assign s_ent     = t_sent'(i_s_rdata);
    assign o_q_re    = rd_en && is_flush;
    assign o_s_re    = rd_en && !is_flush;
    assign o_q_raddr = rd_addr[QAW-1:0];
    assign o_s_raddr = rd_addr[SAW-1:0];

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_left     = r_left;
        n_addr     = r_addr;
        n_o_valid  = r_o_valid && i_stall;
        n_o_pin    = r_o_pin;
        n_o_value  = r_o_value;
        n_o_flags  = r_o_flags;
        n_o_src    = r_o_src;
        n_o_last   = r_o_last;
        n_o_ovf    = r_o_ovf;
        o_pop      = 1'b0;
        o_mem_done = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_addr;

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_addr  = i_job.addr;
                    n_left  = i_job.cnt;
                    n_state = (i_job.kind == JOB_DIRECT) ? B_DIRECT : B_READ;
                end
            end
            B_DIRECT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_pin   = r_job.pin;
                    n_o_value = r_job.value;
                    n_o_flags = r_job.flags;
                    n_o_src   = SRC_DIRECT;
                    n_o_last  = 1'b1;
                    n_o_ovf   = r_job.ovf;
                    n_state   = B_IDLE;
                end
            end
            B_READ: begin
                rd_en   = 1'b1;
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_ovf   = r_job.ovf;
                    n_o_last  = (r_left == RCW'(1));
                    if (is_flush) begin
                        n_o_pin   = q_ent.pin;
                        n_o_value = q_ent.value;
                        n_o_flags = q_ent.flags;
                        n_o_src   = SRC_FLUSH;
                    end else begin
                        n_o_pin   = s_ent.pin;
                        n_o_value = s_ent.value;
                        n_o_flags = '0;
                        n_o_src   = SRC_STEP;
                    end
                    if (r_left == RCW'(1)) begin
                        o_mem_done = 1'b1;
                        n_state    = B_IDLE;
                    end else begin
                        // next read overlaps this emit
                        n_left  = r_left - RCW'(1);
                        n_addr  = addr_next;
                        rd_en   = 1'b1;
                        rd_addr = addr_next;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_job     <= n_job;
        r_left    <= n_left;
        r_addr    <= n_addr;
        r_o_pin   <= n_o_pin;
        r_o_value <= n_o_value;
        r_o_flags <= n_o_flags;
        r_o_src   <= n_o_src;
        r_o_last  <= n_o_last;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_valid         = r_o_valid;
    assign o_write_pin     = r_o_pin;
    assign o_write_value   = r_o_value;
    assign o_write_flags   = r_o_flags;
    assign o_write_source  = r_o_src;
    assign o_last_of_run   = r_o_last;
    assign o_overflow_seen = r_o_ovf;

endmodule

@@ hdl/gpio_command_queue_sequencer.sv @@
// GPIO write queue and step sequencer. A front end takes one request per cycle when not
// stalled, updates the queue and sequencer state and hands write jobs through a two-entry
// job queue to a back end that drives a registered output. An immediate write goes through
// the job queue and the back end's direct state into the output register. The back end
// takes a new immediate write only after the last has gone out, and the front end keeps
// accepting while the job queue has room. A flush streams the queued writes one per cycle
// while the output is not stalled; the front end stalls until the last one is in the output
// register, as it does while a sequencer step is pending. Starting a sequence or advancing
// a step stalls the front end while the step is read out and its delay is fetched from the
// delay memory. Queue and step memories need no clearing after reset.
module gpio_command_queue_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [gcq_pkg::CMD_W-1:0] i_command,
    input  logic [gcq_pkg::PIN_W-1:0] i_pin,
    input  logic [gcq_pkg::VAL_W-1:0] i_value,
    input  logic [gcq_pkg::FLG_W-1:0] i_flags,
    input  logic [gcq_pkg::DLY_W-1:0] i_delay_ms,
    input  logic                      i_step_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_exec_mode,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [gcq_pkg::PIN_W-1:0] o_write_pin,
    output logic [gcq_pkg::VAL_W-1:0] o_write_value,
    output logic [gcq_pkg::FLG_W-1:0] o_write_flags,
    output logic [gcq_pkg::SRC_W-1:0] o_write_source,
    output logic                      o_last_of_run,
    output logic                      o_overflow_seen
);

    import gcq_pkg::*;

    logic             push;
    t_job             push_job;
    logic             jobq_full;
    logic             jobq_empty;
    logic             pop;
    t_job             head_job;
    logic             mem_done;
    t_qwr             qwr;
    t_swr             swr;
    logic             dly_re;
    logic [SAW-1:0]   dly_raddr;
    logic [DLY_W-1:0] dly_rdata;
    logic             q_re;
    logic [QAW-1:0]   q_raddr;
    logic [QW-1:0]    q_rdata;
    logic             s_re;
    logic [SAW-1:0]   s_raddr;
    logic [PVW-1:0]   s_rdata;

    gcq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_pin           (i_pin),
        .i_value         (i_value),
        .i_flags         (i_flags),
        .i_delay_ms      (i_delay_ms),
        .i_step_last     (i_step_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_exec_mode (i_cfg_exec_mode),
        .i_jobq_full     (jobq_full),
        .o_push          (push),
        .o_job           (push_job),
        .i_mem_done      (mem_done),
        .o_qwr           (qwr),
        .o_swr           (swr),
        .o_dly_re        (dly_re),
        .o_dly_raddr     (dly_raddr),
        .i_dly_rdata     (dly_rdata)
    );

    gcq_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (jobq_full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (jobq_empty)
    );

    gcq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (jobq_empty),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_mem_done      (mem_done),
        .o_q_re          (q_re),
        .o_q_raddr       (q_raddr),
        .i_q_rdata       (q_rdata),
        .o_s_re          (s_re),
        .o_s_raddr       (s_raddr),
        .i_s_rdata       (s_rdata),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_pin     (o_write_pin),
        .o_write_value   (o_write_value),
        .o_write_flags   (o_write_flags),
        .o_write_source  (o_write_source),
        .o_last_of_run   (o_last_of_run),
        .o_overflow_seen (o_overflow_seen)
    );

    gcq_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (qwr.we),
        .i_waddr (qwr.addr),
        .i_wdata (qwr.data),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    gcq_ram #(.WIDTH(PVW), .DEPTH(STEP_DEPTH)) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (swr.we),
        .i_waddr (swr.addr),
        .i_wdata (swr.data),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    gcq_ram #(.WIDTH(DLY_W), .DEPTH(STEP_DEPTH)) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (swr.we),
        .i_waddr (swr.addr),
        .i_wdata (swr.delay),
        .i_re    (dly_re),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

endmodule

@@ hdl/gcq_chk.sv @@
module gcq_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [gcq_pkg::PIN_W-1:0] o_write_pin,
    input logic [gcq_pkg::VAL_W-1:0] o_write_value,
    input logic [gcq_pkg::FLG_W-1:0] o_write_flags,
    input logic [gcq_pkg::SRC_W-1:0] o_write_source,
    input logic                      o_last_of_run,
    input logic                      o_overflow_seen
);

    import gcq_pkg::*;

    logic r_ovf_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_taken <= 1'b0;
        end else if (o_valid && !i_stall && o_overflow_seen) begin
            r_ovf_taken <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_write_pin) && $stable(o_write_value)
            && $stable(o_write_flags) && $stable(o_write_source)
            && $stable(o_last_of_run) && $stable(o_overflow_seen))
        else $error("output request changed while stalled");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_ovf_taken |-> o_overflow_seen)
        else $error("overflow flag dropped after being reported");

    a_step_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_write_source == SRC_STEP) |-> (o_write_flags == '0))
        else $error("sequencer step with nonzero flags");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_write_source == SRC_DIRECT) || (o_write_source == SRC_STEP))
            |-> o_last_of_run)
        else $error("single write not marked last");

endmodule

bind gpio_command_queue_sequencer gcq_chk u_gcq_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_write_pin     (o_write_pin),
    .o_write_value   (o_write_value),
    .o_write_flags   (o_write_flags),
    .o_write_source  (o_write_source),
    .o_last_of_run   (o_last_of_run),
    .o_overflow_seen (o_overflow_seen)
);
